FILE: sv/hpts_pkg.sv
// Package for the hashed page table slot insert block.
// Field widths, output packing offsets and the slot search result type.
// No dependencies.
package hpts_pkg;

  localparam int unsigned PageW   = 20;
  localparam int unsigned FrameW  = 20;
  localparam int unsigned GroupW  = 13;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned SlotN   = 8;
  localparam int unsigned SegW    = 4;
  localparam int unsigned ApiW    = 6;
  localparam int unsigned MaskW   = 3;
  localparam int unsigned LowHashW = 10;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 56;

  // output tdata bit offsets
  localparam int unsigned OGrp   = 0;
  localparam int unsigned OSlot  = OGrp + GroupW;
  localparam int unsigned OSec   = OSlot + SlotW;
  localparam int unsigned OSeg   = OSec + 1;
  localparam int unsigned OApi   = OSeg + SegW;
  localparam int unsigned OFrame = OApi + ApiW;
  localparam int unsigned ONc    = OFrame + FrameW;
  localparam int unsigned OGd    = ONc + 1;
  localparam int unsigned OCoh   = OGd + 1;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot;
    logic [SlotN-1:0] occ_next;
  } find_t;

endpackage

FILE: sv/hpts_hash.sv
// Group index hash: primary hash of segment id and page bits, or its complement.
// Depends on hpts_pkg.
module hpts_hash (
  input  logic [hpts_pkg::PageW-1:0]  virt_page_i,
  input  logic                        secondary_i,
  input  logic [hpts_pkg::MaskW-1:0]  mask_i,
  output logic [hpts_pkg::GroupW-1:0] group_o
);
  import hpts_pkg::*;

  logic [15:0]    hash;
  logic [15:0]    hsel;
  logic [MaskW-1:0] hi;

  always_comb begin
    hash    = {12'd0, virt_page_i[PageW-1 -: SegW]} ^ virt_page_i[15:0];
    hsel    = secondary_i ? ~hash : hash;
    hi      = hsel[LowHashW +: MaskW] & mask_i;
    group_o = {hi, hsel[LowHashW-1:0]};
  end

endmodule

FILE: sv/hpts_slot_finder.sv
// Shared slot search: first free slot of a group's occupancy byte.
// Depends on hpts_pkg.
module hpts_slot_finder (
  input  logic [hpts_pkg::SlotN-1:0] occ_i,
  output hpts_pkg::find_t            res_o
);
  import hpts_pkg::*;

  always_comb begin
    res_o = '0;
    for (int i = SlotN - 1; i >= 0; i--) begin
      if (!occ_i[i]) begin
        res_o.found = 1'b1;
        res_o.slot  = SlotW'(i);
      end
    end
    res_o.occ_next = occ_i | (SlotN'(res_o.found) << res_o.slot);
  end

endmodule

FILE: sv/hpts_occ_mem.sv
// Occupancy memory: one byte per group, one write and one registered read port.
// No dependencies.
module hpts_occ_mem #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

FILE: sv/hashed_page_table_slot_insert.sv
// Top level of the hashed page table slot insert block: sequencer and registers.
// Depends on hpts_pkg, hpts_hash, hpts_slot_finder, hpts_occ_mem.
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+-------------------------------------
//  s_axis   | s_axis_tvalid/tready/tdata/tuser | page, frame, io flag
//  m_axis   | m_axis_tvalid/tready/tdata/tuser | entry fields, found flag
//  cfg      | cfg_valid_i/cfg_ready_o/data_i   | table_size_mask
//
// A transaction passes ST_PRI then ST_OUT when the primary group has a free slot, and
// ST_PRI, ST_SEC and ST_OUT otherwise: one registered occupancy read per group through
// the shared slot search. After reset the occupancy memory is cleared, one group a cycle,
// with s_axis_tready low until all GROUP_COUNT groups are written. A stalled result holds
// the sequencer in its last step; the next transaction is taken while that result waits
// on m_axis. GROUP_COUNT must be a power of two.
module hashed_page_table_slot_insert #(
  parameter int unsigned GROUP_COUNT = 8192
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hpts_pkg::InDataW-1:0]    s_axis_tdata,  // virt_page, phys_frame
  input  logic                            s_axis_tuser,  // io_space
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // group_index, slot, used_secondary, segment_id, page_api, frame_out,
  // cache_inhibit, guarded, coherent, zero fill
  output logic [hpts_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tuser,  // found
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hpts_pkg::MaskW-1:0]      cfg_data_i
);
  import hpts_pkg::*;

  localparam int unsigned AW = $clog2(GROUP_COUNT);
  localparam int unsigned IW = (AW > GroupW) ? AW : GroupW;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_PRI   = 5'b00100,
    ST_SEC   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]     clr_q, clr_d;
  logic [MaskW-1:0]  mask_q;
  logic [PageW-1:0]  page_q;
  logic [FrameW-1:0] frame_q;
  logic              io_q;
  logic [AW-1:0]     addr_q, addr_d;
  logic              found_q, found_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic              sec_q, sec_d;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                out_user_q;

  logic               in_acc;
  logic [PageW-1:0]   hash_page;
  logic               hash_sec;
  logic [GroupW-1:0]  hash_grp;
  logic [IW-1:0]      hash_wide;
  logic [AW-1:0]      rd_addr;
  logic [IW-1:0]      addr_wide;
  logic [SlotN-1:0]   rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [SlotN-1:0]   wr_data;
  find_t              find;
  logic               out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  assign hash_page = (state_q == ST_IDLE) ? s_axis_tdata[PageW-1:0] : page_q;
  assign hash_sec  = (state_q == ST_PRI);

  hpts_hash u_hash (
    .virt_page_i (hash_page),
    .secondary_i (hash_sec),
    .mask_i      (mask_q),
    .group_o     (hash_grp)
  );

  assign hash_wide = IW'(hash_grp);
  assign rd_addr   = (state_q == ST_IDLE || state_q == ST_PRI) ? hash_wide[AW-1:0] : addr_q;
  assign addr_wide = IW'(addr_q);

  hpts_occ_mem #(
    .Depth (GROUP_COUNT),
    .Width (SlotN)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  hpts_slot_finder u_find (
    .occ_i (rd_data),
    .res_o (find)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    addr_d  = addr_q;
    found_d = found_q;
    slot_d  = slot_q;
    sec_d   = sec_q;
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = find.occ_next;
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(GROUP_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          addr_d  = rd_addr;
          state_d = ST_PRI;
        end
      end
      ST_PRI: begin
        if (find.found) begin
          wr_en   = 1'b1;
          found_d = 1'b1;
          slot_d  = find.slot;
          sec_d   = 1'b0;
          state_d = ST_OUT;
        end else begin
          addr_d  = rd_addr;
          state_d = ST_SEC;
        end
      end
      ST_SEC: begin
        wr_en   = find.found;
        found_d = find.found;
        slot_d  = find.slot;
        sec_d   = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_data_d = '0;
    if (found_q) begin
      out_data_d[OGrp +: GroupW]   = addr_wide[GroupW-1:0];
      out_data_d[OSlot +: SlotW]   = slot_q;
      out_data_d[OSec]             = sec_q;
      out_data_d[OSeg +: SegW]     = page_q[PageW-1 -: SegW];
      out_data_d[OApi +: ApiW]     = page_q[LowHashW +: ApiW];
      out_data_d[OFrame +: FrameW] = frame_q;
      out_data_d[ONc]              = io_q;
      out_data_d[OGd]              = io_q;
      out_data_d[OCoh]             = !io_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mask_q <= cfg_data_i;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    found_q <= found_d;
    slot_q  <= slot_d;
    sec_q   <= sec_d;
    if (in_acc) begin
      page_q  <= s_axis_tdata[PageW-1:0];
      frame_q <= s_axis_tdata[PageW +: FrameW];
      io_q    <= s_axis_tuser;
    end
    if (state_q == ST_OUT && out_free) begin
      out_user_q <= found_q;
      out_data_q <= out_data_d;
    end
  end

endmodule

FILE: sv/hpts_checker.sv
// Port-level checks for the hashed page table slot insert block, with its bind.
// Depends on hpts_pkg and hashed_page_table_slot_insert.
module hpts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hpts_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import hpts_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // busy after each input transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // no free slot: entry fields all zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss result carries data");

  // attributes consistent on a hit
  a_attr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[ONc] == m_axis_tdata[OGd] && m_axis_tdata[OCoh] != m_axis_tdata[ONc])
    else $error("attribute bits inconsistent");

endmodule

bind hashed_page_table_slot_insert hpts_checker u_hpts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/tb_hashed_page_table_slot_insert.sv
`timescale 1ns / 100ps
// Testbench for hashed_page_table_slot_insert: directed and random page mapping requests,
// each result checked against a slot occupancy tracker kept in the bench.
// Depends on hpts_pkg and the block's RTL.
module tb_hashed_page_table_slot_insert;
  import hpts_pkg::*;

  localparam int unsigned GroupCount = 8192;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandItems  = 1000;

  typedef struct packed {
    logic              found;
    logic [GroupW-1:0] group;
    logic [SlotW-1:0]  slot;
    logic              secondary;
    logic [SegW-1:0]   seg;
    logic [ApiW-1:0]   api;
    logic [FrameW-1:0] frame;
    logic              nc;
    logic              gd;
    logic              coh;
  } pte_entry_t;

  class pteg_tracker;
    logic [SlotN-1:0] occupied [GroupCount];
    logic [MaskW-1:0] size_mask;
    pte_entry_t       pending_entries [$];
    int unsigned      errors;

    function new();
      foreach (occupied[g]) occupied[g] = '0;
      size_mask = '0;
      errors = 0;
    endfunction

    function logic [GroupW-1:0] group_of(logic [PageW-1:0] page, bit secondary);
      logic [15:0] hash;
      hash = {12'b0, page[19:16]} ^ page[15:0];
      if (secondary) hash = ~hash;
      return {hash[12:10] & size_mask, hash[9:0]};
    endfunction

    // first free slot in the primary group, then in the secondary group
    function void take_request(logic [PageW-1:0] page, logic [FrameW-1:0] frame, logic io);
      pte_entry_t e;
      logic [GroupW-1:0] g;
      e = '0;
      for (int pass = 0; pass < 2 && !e.found; pass++) begin
        g = group_of(page, pass != 0);
        for (int s = 0; s < SlotN && !e.found; s++) begin
          if (!occupied[g][s]) begin
            occupied[g][s] = 1'b1;
            e.found     = 1'b1;
            e.group     = g;
            e.slot      = s[SlotW-1:0];
            e.secondary = (pass != 0);
            e.seg       = page[19:16];
            e.api       = page[15:10];
            e.frame     = frame;
            e.nc        = io;
            e.gd        = io;
            e.coh       = !io;
          end
        end
      end
      pending_entries.push_back(e);
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_entry(logic [OutDataW-1:0] data, logic found);
      pte_entry_t w;
      if (pending_entries.size() == 0) begin
        $error("result transaction with no request pending");
        errors++;
        return;
      end
      w = pending_entries.pop_front();
      cmp("found", 32'(w.found), 32'(found));
      cmp("group_index", 32'(w.group), 32'(data[OGrp +: GroupW]));
      cmp("slot", 32'(w.slot), 32'(data[OSlot +: SlotW]));
      cmp("used_secondary", 32'(w.secondary), 32'(data[OSec]));
      cmp("segment_id", 32'(w.seg), 32'(data[OSeg +: SegW]));
      cmp("page_api", 32'(w.api), 32'(data[OApi +: ApiW]));
      cmp("frame_out", 32'(w.frame), 32'(data[OFrame +: FrameW]));
      cmp("cache_inhibit", 32'(w.nc), 32'(data[ONc]));
      cmp("guarded", 32'(w.gd), 32'(data[OGd]));
      cmp("coherent", 32'(w.coh), 32'(data[OCoh]));
      cmp("zero_fill", '0, 32'(data[OutDataW-1:OCoh+1]));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [MaskW-1:0]    cfg_data_i = '0;

  pteg_tracker tracker = new();
  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  int unsigned cycles = 0;

  hashed_page_table_slot_insert #(
    .GROUP_COUNT(GroupCount)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(0, 99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_entry(m_axis_tdata, m_axis_tuser);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.take_request(s_axis_tdata[0 +: PageW], s_axis_tdata[PageW +: FrameW],
                             s_axis_tuser);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // called and returns at a falling edge; tvalid stays high for a back-to-back transaction
  task automatic send_request(logic [PageW-1:0] page, logic [FrameW-1:0] frame, logic io);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {frame, page};
    s_axis_tuser  = io;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (tracker.pending_entries.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_size_mask(logic [MaskW-1:0] value);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.size_mask = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    logic [PageW-1:0]  page;
    logic [GroupW-1:0] hash_pool [6];
    logic [MaskW-1:0]  mask;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle_pct = 20;
    dst_idle_pct = 66;
    write_size_mask('0);

    // one page 17 times: primary group fills, then secondary, then both full
    for (int i = 0; i < 17; i++) begin
      send_request(20'h12345, (i % 2) ? 20'hFFFFF : 20'h00000, 1'(i % 2));
    end
    send_request(20'h00000, 20'hFFFFF, 1'b0);
    send_request(20'hFFFFF, 20'h00000, 1'b1);
    send_request(20'hA5C3F, 20'h5A5A5, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 20;
          dst_idle_pct = 66;
          mask = 3'd7;
        end
        1: begin
          src_idle_pct = 66;
          dst_idle_pct = 20;
          mask = MaskW'($urandom_range(1, 6));
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
          mask = 3'd0;
        end
      endcase
      write_size_mask(mask);
      foreach (hash_pool[k]) hash_pool[k] = GroupW'($urandom_range(0, 8191));
      for (int n = 0; n < RandItems / 3 + 1; n++) begin
        page = PageW'($urandom_range(0, 20'hFFFFF));
        // most requests land on a few hash values so groups fill up and overflow
        if ($urandom_range(0, 99) < 75) begin
          page[12:0] = hash_pool[$urandom_range(0, 5)] ^ {9'b0, page[19:16]};
        end
        send_request(page, FrameW'($urandom_range(0, 20'hFFFFF)), 1'($urandom_range(0, 1)));
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
